// ===== rtl/term_table_load_sort_core_macros.svh =====
// Assertion macros used by the checker of the term table core.
// Each macro expands to one labeled concurrent assertion on a rising clock edge.
`ifndef TERM_TABLE_LOAD_SORT_CORE_MACROS_SVH
`define TERM_TABLE_LOAD_SORT_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TTLS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TTLS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ttls_pkg.sv =====
// Package for the term table load-and-sort core: widths, codes and the
// sequencer state type. No dependencies.
package ttls_pkg;

  localparam int MAX_TERMS_DEF = 64;
  localparam int TERM_BITS_DEF = 16;

  localparam int NUM_W    = 16;
  localparam int IDX_W    = 7;
  localparam int CNT_W    = 7;
  localparam int DATA_W   = 32;
  localparam int PADDR_W  = 3;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_READ   = 1'b1;

  localparam logic REG_MINTERM  = 1'b0;
  localparam logic REG_DONTCARE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SORT_KEY,
    ST_SORT_LOAD,
    ST_SORT_CMP,
    ST_SORT_PLACE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [NUM_W-1:0] number;
    logic             dont_care;
    logic             full;
    logic             rejected;
  } result_t;

endpackage

// ===== rtl/ttls_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ttls_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/ttls_cfg.sv =====
// APB register block for the term table core: the two entry counts and the
// saturated count of slots in use. Depends on ttls_pkg.
module ttls_cfg import ttls_pkg::*; #(
  parameter int MAX_TERMS = MAX_TERMS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [PADDR_W-1:0]                 paddr,
  input  logic [DATA_W-1:0]                  pwdata,
  output logic [DATA_W-1:0]                  prdata,
  output logic                               pready,
  output logic [$clog2(MAX_TERMS+1)-1:0]     slots
);

  localparam int FILL_W = $clog2(MAX_TERMS + 1);
  localparam int CW     = (FILL_W > CNT_W + 1) ? FILL_W : CNT_W + 1;

  logic [CNT_W-1:0] minterm_count;
  logic [CNT_W-1:0] dontcare_count;
  logic             wr_en;
  logic [CNT_W:0]   sum;
  logic [CW-1:0]    sum_cw;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      minterm_count  <= '0;
      dontcare_count <= '0;
    end else if (wr_en) begin
      case (paddr[2])
        REG_MINTERM:  minterm_count  <= pwdata[CNT_W-1:0];
        REG_DONTCARE: dontcare_count <= pwdata[CNT_W-1:0];
        default:      minterm_count  <= minterm_count;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MINTERM:  prdata = {(DATA_W - CNT_W)'(0), minterm_count};
      REG_DONTCARE: prdata = {(DATA_W - CNT_W)'(0), dontcare_count};
      default:      prdata = '0;
    endcase
  end

  assign sum    = {1'b0, minterm_count} + {1'b0, dontcare_count};
  assign sum_cw = CW'(sum);

  always_comb begin
    if (sum_cw > CW'(MAX_TERMS)) begin
      slots = FILL_W'(MAX_TERMS);
    end else begin
      slots = sum_cw[FILL_W-1:0];
    end
  end

endmodule

// ===== rtl/term_table_load_sort_core.sv =====
// Channel  Dir  Handshake            Beat contents
// in       in   in_valid/in_stall    operation, term_number, dont_care, read_index
// out      out  out_valid/out_stall  read_number, read_dont_care, table_full,
//                                    append_rejected
// cfg      in   psel/penable/pready  paddr, pwdata, prdata
//
// An append goes from IDLE to EMIT; a read passes through READ first, as the one-write,
// one-read term RAM has a registered read port. The append that fills the table adds a
// stable insertion sort of the filled entries, run by one compare unit.
// in_stall is high from an accepted beat until its result enters the output
// register; a stalled result holds there and delays the next one.
// Reset clears only the control state; slots at or past the fill count read as zero.
// Top level of the term table core. Depends on ttls_pkg, ttls_cfg, ttls_ram.
module term_table_load_sort_core import ttls_pkg::*; #(
  parameter int MAX_TERMS = MAX_TERMS_DEF,
  parameter int TERM_BITS = TERM_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               operation,
  input  logic [NUM_W-1:0]   term_number,
  input  logic               dont_care,
  input  logic [IDX_W-1:0]   read_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [NUM_W-1:0]   read_number,
  output logic               read_dont_care,
  output logic               table_full,
  output logic               append_rejected,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  localparam int ADDR_W = $clog2(MAX_TERMS);
  localparam int FILL_W = $clog2(MAX_TERMS + 1);
  localparam int CW     = (FILL_W > IDX_W + 1) ? FILL_W : IDX_W + 1;
  localparam int ENT_W  = TERM_BITS + 1;

  state_t state, state_next;

  logic [FILL_W-1:0] slots;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_inc;
  logic [FILL_W-1:0] i;
  logic [FILL_W-1:0] i_inc;
  logic [ADDR_W-1:0] j;
  logic [ENT_W-1:0]  key;
  logic              rd_hit;
  result_t           res;

  logic              accept;
  logic              out_free;
  logic              full_now;
  logic              full_after;
  logic              need_sort;
  logic              shift;
  logic              more;

  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr;
  logic [ENT_W-1:0]         ram_wdata;
  logic [ADDR_W-1:0]        ram_raddr;
  logic [ENT_W-1:0]         ram_rdata;

  logic [TERM_BITS+NUM_W-1:0] in_num_wide;
  logic [TERM_BITS-1:0]       in_num;
  logic [NUM_W+TERM_BITS-1:0] rd_num_wide;
  logic [IDX_W+ADDR_W-1:0]    idx_wide;

  ttls_cfg #(
    .MAX_TERMS (MAX_TERMS)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .slots   (slots)
  );

  ttls_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_TERMS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_num_wide = {TERM_BITS'(0), term_number};
  assign in_num      = in_num_wide[TERM_BITS-1:0];
  assign rd_num_wide = {NUM_W'(0), ram_rdata[TERM_BITS-1:0]};
  assign idx_wide    = {ADDR_W'(0), read_index};

  assign in_stall   = (state != ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign fill_inc   = fill + FILL_W'(1);
  assign i_inc      = i + FILL_W'(1);
  assign full_now   = (fill >= slots);
  assign full_after = (fill_inc >= slots);
  assign need_sort  = full_after && (fill_inc >= FILL_W'(2));
  assign shift      = (ram_rdata[TERM_BITS-1:0] > key[TERM_BITS-1:0]);
  assign more       = (i_inc < fill);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (operation == OP_READ) begin
            state_next = ST_READ;
          end else if (!full_now && need_sort) begin
            state_next = ST_SORT_KEY;
          end else begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_READ:      state_next = ST_EMIT;
      ST_SORT_KEY:  state_next = ST_SORT_LOAD;
      ST_SORT_LOAD: state_next = ST_SORT_CMP;
      ST_SORT_CMP: begin
        if (!shift || j == ADDR_W'(1)) begin
          state_next = ST_SORT_PLACE;
        end
      end
      ST_SORT_PLACE: begin
        state_next = more ? ST_SORT_KEY : ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = fill[ADDR_W-1:0];
    ram_wdata = {dont_care, in_num};
    ram_raddr = '0;
    case (state)
      ST_IDLE: begin
        ram_raddr = idx_wide[ADDR_W-1:0];
        if (accept && operation == OP_APPEND && !full_now) begin
          ram_we = 1'b1;
        end
      end
      ST_SORT_KEY: begin
        ram_raddr = i[ADDR_W-1:0];
      end
      ST_SORT_LOAD: begin
        ram_raddr = j - ADDR_W'(1);
      end
      ST_SORT_CMP: begin
        ram_raddr = j - ADDR_W'(2);
        if (shift) begin
          ram_we    = 1'b1;
          ram_waddr = j;
          ram_wdata = ram_rdata;
        end
      end
      ST_SORT_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = j;
        ram_wdata = key;
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (operation == OP_READ) begin
              rd_hit <= (CW'(read_index) < CW'(fill)) && (CW'(read_index) < CW'(slots));
            end else if (full_now) begin
              res <= '{number: '0, dont_care: 1'b0, full: 1'b1, rejected: 1'b1};
            end else begin
              fill <= fill_inc;
              i    <= FILL_W'(1);
              res  <= '{number: '0, dont_care: 1'b0, full: full_after, rejected: 1'b0};
            end
          end
        end
        ST_READ: begin
          res.number    <= rd_hit ? rd_num_wide[NUM_W-1:0] : '0;
          res.dont_care <= rd_hit && ram_rdata[TERM_BITS];
          res.full      <= full_now;
          res.rejected  <= 1'b0;
        end
        ST_SORT_KEY: begin
          j <= i[ADDR_W-1:0];
        end
        ST_SORT_LOAD: begin
          key <= ram_rdata;
        end
        ST_SORT_CMP: begin
          if (shift) begin
            j <= j - ADDR_W'(1);
          end
        end
        ST_SORT_PLACE: begin
          i <= i_inc;
        end
        ST_EMIT: begin
          if (out_free) begin
            read_number     <= res.number;
            read_dont_care  <= res.dont_care;
            table_full      <= res.full;
            append_rejected <= res.rejected;
          end
        end
        default: i <= i;
      endcase
      if (state == ST_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/ttls_checker.sv =====
// Port-level checker for the term table core, bound to the top level.
// Depends on ttls_pkg and term_table_load_sort_core_macros.svh.
`include "term_table_load_sort_core_macros.svh"

module ttls_checker import ttls_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [NUM_W-1:0] read_number,
  input logic             read_dont_care,
  input logic             table_full,
  input logic             append_rejected
);

  `TTLS_ASSERT_NXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall, "accepted beat did not make the core busy")
  `TTLS_ASSERT_IMP(a_reject_shape, clk, rst, out_valid && append_rejected, table_full && read_number == '0 && !read_dont_care, "rejected append with bad result fields")
  `TTLS_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(read_number) && $stable(table_full), "stalled result beat changed")
  `TTLS_ASSERT_IMP(a_out_drop, clk, rst, !$past(rst) && $fell(out_valid), !$past(out_stall), "result beat dropped while stalled")

endmodule

bind term_table_load_sort_core ttls_checker u_checker (.*);

// ===== dv/testbench.sv =====
// Self-checking testbench for term_table_load_sort_core: appends, reads, the fill-time
// sort and register changes, checked beat by beat against an in-file table predictor.
// Depends on ttls_pkg and the core RTL.
module testbench;
  import ttls_pkg::*;

  localparam int DEPTH          = MAX_TERMS_DEF;
  localparam int RANDOM_ITEMS   = 730;
  localparam int IDLE_PCT       = 14;
  localparam int DRAIN_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  localparam logic [PADDR_W-1:0] ADDR_MINTERM  = {REG_MINTERM, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_DONTCARE = {REG_DONTCARE, 2'b00};

  localparam result_t ZERO_OPEN = '{number: '0, dont_care: 1'b0, full: 1'b0, rejected: 1'b0};
  localparam result_t ZERO_FULL = '{number: '0, dont_care: 1'b0, full: 1'b1, rejected: 1'b0};
  localparam result_t REJ_FULL  = '{number: '0, dont_care: 1'b0, full: 1'b1, rejected: 1'b1};

  typedef struct {
    bit                 is_cfg;
    logic [PADDR_W-1:0] addr;
    int unsigned        value;
    logic               op;
    logic [NUM_W-1:0]   num;
    logic               dc;
    logic [IDX_W-1:0]   idx;
    bit                 typed;
    result_t            want;
  } row_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic               operation;
  logic [NUM_W-1:0]   term_number;
  logic               dont_care;
  logic [IDX_W-1:0]   read_index;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [NUM_W-1:0]   read_number;
  logic               read_dont_care;
  logic               table_full;
  logic               append_rejected;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  logic [NUM_W-1:0] shadow_num [DEPTH];
  logic             shadow_dc  [DEPTH];
  int unsigned      shadow_fill;
  int unsigned      shadow_minterms;
  int unsigned      shadow_dontcares;

  result_t     term_replies [$];
  int unsigned err_count = 0;
  int unsigned replies_seen = 0;
  int unsigned cyc = 0;
  int unsigned quiet_cycles = 0;
  logic        calm;

  assign calm = (cyc >= 3000) && (cyc < 6000);

  term_table_load_sort_core dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .operation       (operation),
    .term_number     (term_number),
    .dont_care       (dont_care),
    .read_index      (read_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .read_number     (read_number),
    .read_dont_care  (read_dont_care),
    .table_full      (table_full),
    .append_rejected (append_rejected),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned slots_in_use();
    int unsigned s;
    s = shadow_minterms + shadow_dontcares;
    return (s > DEPTH) ? DEPTH : s;
  endfunction

  function automatic bit table_is_full();
    return shadow_fill >= slots_in_use();
  endfunction

  function automatic void sort_terms();
    int unsigned      n;
    int unsigned      i;
    int unsigned      j;
    logic [NUM_W-1:0] key_num;
    logic             key_dc;
    n = (shadow_fill > DEPTH) ? DEPTH : shadow_fill;
    for (i = 1; i < n; i++) begin
      key_num = shadow_num[i];
      key_dc  = shadow_dc[i];
      j = i;
      while (j > 0 && shadow_num[j-1] > key_num) begin
        shadow_num[j] = shadow_num[j-1];
        shadow_dc[j]  = shadow_dc[j-1];
        j--;
      end
      shadow_num[j] = key_num;
      shadow_dc[j]  = key_dc;
    end
  endfunction

  function automatic result_t apply_term_op(logic op, logic [NUM_W-1:0] num, logic dc,
                                            logic [IDX_W-1:0] idx);
    result_t r;
    r = ZERO_OPEN;
    if (op == OP_APPEND) begin
      if (table_is_full()) begin
        r.rejected = 1'b1;
      end else begin
        if (shadow_fill < DEPTH) begin
          shadow_num[shadow_fill] = num;
          shadow_dc[shadow_fill]  = dc;
        end
        shadow_fill++;
        if (table_is_full()) begin
          sort_terms();
        end
      end
    end else if (idx < slots_in_use() && idx < DEPTH) begin
      r.number    = shadow_num[idx];
      r.dont_care = shadow_dc[idx];
    end
    r.full = table_is_full();
    return r;
  endfunction

  function automatic row_t cfg_row(logic [PADDR_W-1:0] addr, int unsigned value);
    row_t r;
    r.is_cfg = 1'b1;
    r.addr   = addr;
    r.value  = value;
    r.op     = OP_READ;
    r.num    = '0;
    r.dc     = 1'b0;
    r.idx    = '0;
    r.typed  = 1'b0;
    r.want   = ZERO_OPEN;
    return r;
  endfunction

  function automatic row_t beat_row(logic op, logic [NUM_W-1:0] num, logic dc,
                                    logic [IDX_W-1:0] idx, bit typed, result_t want);
    row_t r;
    r.is_cfg = 1'b0;
    r.addr   = '0;
    r.value  = 0;
    r.op     = op;
    r.num    = num;
    r.dc     = dc;
    r.idx    = idx;
    r.typed  = typed;
    r.want   = want;
    return r;
  endfunction

  function automatic logic [NUM_W-1:0] rand_term();
    case ($urandom_range(0, 3))
      0: return NUM_W'($urandom());
      1: return $urandom_range(0, 1) ? '1 : '0;
      default: return NUM_W'($urandom_range(0, 7));
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] rand_index();
    int unsigned s;
    s = slots_in_use();
    if (s > 0 && $urandom_range(0, 9) < 7) begin
      return IDX_W'($urandom_range(0, s - 1));
    end
    return IDX_W'($urandom_range(0, 127));
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch on reply %0d: %s got %0h want %0h", replies_seen, what, got, want);
    err_count++;
  endtask

  // Called at a falling edge; returns at a falling edge with the input channel idle
  // and every pending reply drained.
  task automatic wait_quiet();
    in_valid = 1'b0;
    while (term_replies.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [PADDR_W-1:0] addr, int unsigned value);
    wait_quiet();
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_MINTERM) begin
      shadow_minterms = value & 32'h7F;
    end else begin
      shadow_dontcares = value & 32'h7F;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic push_beat(logic op, logic [NUM_W-1:0] num, logic dc, logic [IDX_W-1:0] idx,
                           bit typed, result_t want);
    result_t predicted;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    operation   = op;
    term_number = num;
    dont_care   = dc;
    read_index  = idx;
    do @(posedge clk); while (in_stall);
    predicted = apply_term_op(op, num, dc, idx);
    term_replies.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic push_random(logic op);
    push_beat(op, rand_term(), 1'($urandom_range(0, 1)), rand_index(), 1'b0, ZERO_OPEN);
  endtask

  always @(negedge clk) begin
    out_stall = !calm && ($urandom_range(0, 99) < IDLE_PCT);
  end

  always @(posedge clk) begin : check_replies
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (term_replies.size() == 0) begin
        report_mismatch("beat with no reply pending", 32'(read_number), 0);
      end else begin
        want = term_replies.pop_front();
        if (read_number !== want.number) begin
          report_mismatch("read_number", 32'(read_number), 32'(want.number));
        end
        if (read_dont_care !== want.dont_care) begin
          report_mismatch("read_dont_care", 32'(read_dont_care), 32'(want.dont_care));
        end
        if (table_full !== want.full) begin
          report_mismatch("table_full", 32'(table_full), 32'(want.full));
        end
        if (append_rejected !== want.rejected) begin
          report_mismatch("append_rejected", 32'(append_rejected), 32'(want.rejected));
        end
      end
      replies_seen++;
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pwrite && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    row_t        script [$];
    int unsigned items;
    int unsigned target;
    int unsigned mt;
    int unsigned k;
    int unsigned extra;

    rst         = 1'b1;
    in_valid    = 1'b0;
    operation   = OP_APPEND;
    term_number = '0;
    dont_care   = 1'b0;
    read_index  = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    for (k = 0; k < DEPTH; k++) begin
      shadow_num[k] = '0;
      shadow_dc[k]  = 1'b0;
    end
    shadow_fill      = 0;
    shadow_minterms  = 0;
    shadow_dontcares = 0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    script.push_back(beat_row(OP_READ,   16'h0000, 1'b0, 7'd0,   1'b1, ZERO_FULL));
    script.push_back(beat_row(OP_APPEND, 16'hFFFF, 1'b1, 7'd0,   1'b1, REJ_FULL));
    script.push_back(beat_row(OP_READ,   16'h0000, 1'b0, 7'd127, 1'b1, ZERO_FULL));
    script.push_back(cfg_row(ADDR_MINTERM, 2));
    script.push_back(cfg_row(ADDR_DONTCARE, 1));
    script.push_back(beat_row(OP_READ,   16'h0000, 1'b0, 7'd0,   1'b1, ZERO_OPEN));
    script.push_back(beat_row(OP_APPEND, 16'hFFFF, 1'b1, 7'd127, 1'b1, ZERO_OPEN));
    script.push_back(beat_row(OP_APPEND, 16'h0000, 1'b0, 7'd0,   1'b1, ZERO_OPEN));
    script.push_back(beat_row(OP_APPEND, 16'hFFFF, 1'b0, 7'd0,   1'b0, ZERO_OPEN));
    script.push_back(beat_row(OP_READ,   16'h0000, 1'b0, 7'd0,   1'b0, ZERO_OPEN));
    script.push_back(beat_row(OP_READ,   16'hFFFF, 1'b1, 7'd1,   1'b0, ZERO_OPEN));
    script.push_back(beat_row(OP_READ,   16'h0000, 1'b0, 7'd2,   1'b0, ZERO_OPEN));
    script.push_back(beat_row(OP_READ,   16'h0000, 1'b0, 7'd3,   1'b1, ZERO_FULL));
    script.push_back(beat_row(OP_APPEND, 16'h1234, 1'b1, 7'd0,   1'b1, REJ_FULL));
    script.push_back(cfg_row(ADDR_MINTERM, 64));
    script.push_back(cfg_row(ADDR_DONTCARE, 64));
    script.push_back(beat_row(OP_READ,   16'h0000, 1'b0, 7'd63,  1'b1, ZERO_OPEN));
    script.push_back(beat_row(OP_READ,   16'h0000, 1'b0, 7'd64,  1'b1, ZERO_OPEN));
    script.push_back(beat_row(OP_READ,   16'h0000, 1'b0, 7'd127, 1'b1, ZERO_OPEN));
    script.push_back(beat_row(OP_APPEND, 16'h8000, 1'b1, 7'd5,   1'b0, ZERO_OPEN));
    script.push_back(cfg_row(ADDR_MINTERM, 1));
    script.push_back(cfg_row(ADDR_DONTCARE, 0));
    script.push_back(beat_row(OP_READ,   16'h0000, 1'b0, 7'd0,   1'b0, ZERO_OPEN));
    script.push_back(beat_row(OP_READ,   16'h0000, 1'b0, 7'd2,   1'b1, ZERO_FULL));
    script.push_back(beat_row(OP_APPEND, 16'h00FF, 1'b0, 7'd0,   1'b1, REJ_FULL));
    script.push_back(cfg_row(ADDR_MINTERM, 0));
    script.push_back(beat_row(OP_READ,   16'h0000, 1'b0, 7'd0,   1'b1, ZERO_FULL));

    foreach (script[r]) begin
      if (script[r].is_cfg) begin
        write_reg(script[r].addr, script[r].value);
      end else begin
        push_beat(script[r].op, script[r].num, script[r].dc, script[r].idx,
                  script[r].typed, script[r].want);
      end
    end

    // Each phase sets new counts while idle, fills the table with random terms mixed
    // with reads, then reads back every slot and one past it, or issues random reads, and adds some noise.
    items = 0;
    while (items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: target = (shadow_fill < DEPTH) ?
                                   shadow_fill + $urandom_range(1, 10) : DEPTH;
        6, 7: target = $urandom_range(0, DEPTH);
        default: target = DEPTH + $urandom_range(0, DEPTH);
      endcase
      if (target > 2 * DEPTH) begin
        target = 2 * DEPTH;
      end
      mt = (target > DEPTH) ? $urandom_range(target - DEPTH, DEPTH) : $urandom_range(0, target);
      write_reg(ADDR_MINTERM, mt);
      write_reg(ADDR_DONTCARE, target - mt);

      while (!table_is_full() && items < RANDOM_ITEMS) begin
        push_random(($urandom_range(0, 3) == 0) ? OP_READ : OP_APPEND);
        items++;
      end
      if ($urandom_range(0, 3) == 0) begin
        wait_quiet();
      end
      if ($urandom_range(0, 1) == 0) begin
        for (k = 0; k <= slots_in_use(); k++) begin
          push_beat(OP_READ, rand_term(), 1'($urandom_range(0, 1)), IDX_W'(k), 1'b0, ZERO_OPEN);
          items++;
        end
      end else begin
        repeat ($urandom_range(4, 16)) begin
          push_random(OP_READ);
          items++;
        end
      end
      extra = $urandom_range(2, 8);
      repeat (extra) begin
        push_random(1'($urandom_range(0, 1)));
        items++;
      end
    end

    in_valid = 1'b0;
    while (term_replies.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ttls_pkg.sv
rtl/ttls_ram.sv
rtl/ttls_cfg.sv
rtl/term_table_load_sort_core.sv
rtl/ttls_checker.sv
dv/testbench.sv
